>>> design/fdm_pkg.sv
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared widths, constants and types of the frame difference metrics core.
// ----------------------------------------------------------------------------
package fdm_pkg;

   localparam int unsigned FDM_MAX_PIXELS_DEFAULT = 131072;
   localparam int unsigned FRAME_PIXELS_W         = 18;
   localparam int unsigned FRAME_PIXELS_RESET     = 76800;

   localparam int unsigned LUMA_W         = 8;
   localparam int unsigned SQUARE_W       = 2 * LUMA_W;
   localparam int unsigned FRAME_NUMBER_W = 32;
   localparam int unsigned SUM_SQUARES_W  = 33;
   localparam int unsigned SUM_ABSOLUTE_W = 25;
   localparam int unsigned RMS_ROOT_W     = 17;

   localparam logic [SUM_SQUARES_W-1:0]  SQ_MAX  = '1;
   localparam logic [SUM_ABSOLUTE_W-1:0] ABS_MAX = '1;

   // The root is built one bit per step from two radicand bits per step.
   localparam int unsigned SQRT_STEPS = RMS_ROOT_W;
   localparam int unsigned STEP_W     = $clog2(SQRT_STEPS);
   localparam int unsigned RADICAND_W = 2 * SQRT_STEPS;
   localparam int unsigned REMAINDER_W = RMS_ROOT_W + 3;

   typedef struct packed {
      logic [FRAME_NUMBER_W-1:0] frame_number;
      logic                      first_frame;
      logic [SUM_SQUARES_W-1:0]  sum_squares;
      logic [SUM_ABSOLUTE_W-1:0] sum_absolute;
   } frame_sum_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

   typedef enum logic [1:0] {
      SQRT_IDLE,
      SQRT_RUN,
      SQRT_DONE
   } sqrt_state_type;

endpackage

>>> design/fdm_pixel_ram.sv
// ----------------------------------------------------------------------------
// fdm_pixel_ram
// Previous-frame pixel store: one port, read-first, registered read data.
// ----------------------------------------------------------------------------
module fdm_pixel_ram
   import fdm_pkg::*;
#(
   parameter int unsigned DEPTH = FDM_MAX_PIXELS_DEFAULT,
   parameter int unsigned AW    = $clog2(FDM_MAX_PIXELS_DEFAULT)
) (
   input  logic              clock,
   input  logic              access,
   input  logic [AW-1:0]     addr,
   input  logic [LUMA_W-1:0] wr_data,
   output logic [LUMA_W-1:0] rd_data
);

   logic [LUMA_W-1:0] mem [DEPTH];
   logic [LUMA_W-1:0] rd_data_ff;

   // The read returns the old pixel while the new one is written in its place.
   always_ff @(posedge clock) begin
      if (access) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/fdm_accum.sv
// ----------------------------------------------------------------------------
// fdm_accum
// Difference, square and saturating accumulation of one frame's metrics.
// ----------------------------------------------------------------------------
module fdm_accum
   import fdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pix_valid,
   input  logic              pix_last,
   input  logic [LUMA_W-1:0] pix_luma,
   input  logic [LUMA_W-1:0] old_luma,
   output logic              last_in_flight,
   output logic              sum_valid,
   output frame_sum_type     sum
);

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_last_ff, s1_last_in;
   logic [LUMA_W-1:0]         s1_luma_ff;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_last_ff, s2_last_in;
   logic [LUMA_W-1:0]         s2_abs_ff, s2_abs_in;
   logic [SQUARE_W-1:0]       s2_sq_ff, s2_sq_in;
   logic [SUM_SQUARES_W-1:0]  sq_acc_ff, sq_acc_in;
   logic [SUM_ABSOLUTE_W-1:0] abs_acc_ff, abs_acc_in;
   logic                      primed_ff, primed_in;
   logic [FRAME_NUMBER_W-1:0] frame_count_ff, frame_count_in;
   logic [SUM_SQUARES_W:0]    sq_sum;
   logic [SUM_ABSOLUTE_W:0]   abs_sum;
   logic [SUM_SQUARES_W-1:0]  sq_sat;
   logic [SUM_ABSOLUTE_W-1:0] abs_sat;
   logic                      frame_end;

   // Stage one: the stored pixel has arrived from the store.
   assign s1_valid_in = pix_valid;
   assign s1_last_in  = pix_valid & pix_last;

   always_comb begin
      if (s1_luma_ff >= old_luma) begin
         s2_abs_in = s1_luma_ff - old_luma;
      end else begin
         s2_abs_in = old_luma - s1_luma_ff;
      end
      // The first frame is only stored, so it contributes nothing.
      if (!primed_ff) begin
         s2_abs_in = '0;
      end
      s2_sq_in    = s2_abs_in * s2_abs_in;
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_valid_ff & s1_last_ff;
   end

   // Stage two: saturating accumulation and frame end.
   always_comb begin
      sq_sum  = {1'b0, sq_acc_ff} + (SUM_SQUARES_W + 1)'(s2_sq_ff);
      abs_sum = {1'b0, abs_acc_ff} + (SUM_ABSOLUTE_W + 1)'(s2_abs_ff);
      sq_sat  = (sq_sum > {1'b0, SQ_MAX}) ? SQ_MAX : sq_sum[SUM_SQUARES_W-1:0];
      abs_sat = (abs_sum > {1'b0, ABS_MAX}) ? ABS_MAX : abs_sum[SUM_ABSOLUTE_W-1:0];
      frame_end = s2_valid_ff & s2_last_ff;

      sq_acc_in      = sq_acc_ff;
      abs_acc_in     = abs_acc_ff;
      primed_in      = primed_ff;
      frame_count_in = frame_count_ff;
      if (s2_valid_ff) begin
         if (s2_last_ff) begin
            sq_acc_in      = '0;
            abs_acc_in     = '0;
            primed_in      = 1'b1;
            frame_count_in = frame_count_ff + FRAME_NUMBER_W'(1);
         end else begin
            sq_acc_in  = sq_sat;
            abs_acc_in = abs_sat;
         end
      end
   end

   always_comb begin
      sum.frame_number = frame_count_ff;
      sum.first_frame  = ~primed_ff;
      sum.sum_squares  = primed_ff ? sq_sat : '0;
      sum.sum_absolute = primed_ff ? abs_sat : '0;
   end

   assign sum_valid      = frame_end;
   assign last_in_flight = (s1_valid_ff & s1_last_ff) | frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s1_last_ff     <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s2_last_ff     <= 1'b0;
         sq_acc_ff      <= '0;
         abs_acc_ff     <= '0;
         primed_ff      <= 1'b0;
         frame_count_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         s1_last_ff     <= s1_last_in;
         s2_valid_ff    <= s2_valid_in;
         s2_last_ff     <= s2_last_in;
         sq_acc_ff      <= sq_acc_in;
         abs_acc_ff     <= abs_acc_in;
         primed_ff      <= primed_in;
         frame_count_ff <= frame_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_luma_ff <= pix_luma;
      s2_abs_ff  <= s2_abs_in;
      s2_sq_ff   <= s2_sq_in;
   end

endmodule

>>> design/fdm_isqrt.sv
// ----------------------------------------------------------------------------
// fdm_isqrt
// Iterative floor square root of the frame's sum of squares, one root bit
// per cycle; holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module fdm_isqrt
   import fdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  frame_sum_type         sum_in,
   input  logic                  take,
   output sqrt_status_type       status,
   output frame_sum_type         sum_out,
   output logic [RMS_ROOT_W-1:0] root
);

   sqrt_state_type             state_ff, state_in;
   logic [STEP_W-1:0]          step_ff;
   logic [RADICAND_W-1:0]      rad_ff;
   logic [REMAINDER_W-1:0]     rem_ff;
   logic [RMS_ROOT_W-1:0]      root_ff;
   frame_sum_type              sum_ff;
   logic [REMAINDER_W-1:0]     rem_shift;
   logic [REMAINDER_W-1:0]     trial;
   logic                       fits;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQRT_IDLE: begin
            if (start) begin
               state_in = SQRT_RUN;
            end
         end
         SQRT_RUN: begin
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = SQRT_DONE;
            end
         end
         SQRT_DONE: begin
            if (take) begin
               state_in = SQRT_IDLE;
            end
         end
         default: state_in = SQRT_IDLE;
      endcase
   end

   always_comb begin
      status.busy = 1'b0;
      status.done = 1'b0;
      unique case (state_ff)
         SQRT_IDLE: status.busy = 1'b0;
         SQRT_RUN:  status.busy = 1'b1;
         SQRT_DONE: begin
            status.busy = 1'b1;
            status.done = 1'b1;
         end
         default: status.busy = 1'b0;
      endcase
   end

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {rem_ff[REMAINDER_W-3:0], rad_ff[RADICAND_W-1 -: 2]};
      trial     = REMAINDER_W'({root_ff, 2'b01});
      fits      = rem_shift >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQRT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SQRT_IDLE && start) begin
         sum_ff  <= sum_in;
         rad_ff  <= RADICAND_W'(sum_in.sum_squares);
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == SQRT_RUN) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? rem_shift - trial : rem_shift;
         root_ff <= {root_ff[RMS_ROOT_W-2:0], fits};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign sum_out = sum_ff;
   assign root    = root_ff;

endmodule

>>> design/frame_difference_metrics_core.sv
// ----------------------------------------------------------------------------
// frame_difference_metrics_core
// Per-frame sum of squared and absolute luma differences against the
// previous frame, with the floor square root of the squared sum.
// ----------------------------------------------------------------------------
// Within a frame the core takes one pixel beat per cycle: each beat reads the
// old pixel from the single-port frame store and writes the new one in the
// same access, and the difference and accumulation follow in two pipeline
// stages. At the last pixel of a frame, input stalls while that pixel drains
// the pipeline and the bit-serial square root runs (one root bit per step),
// and until the finished root is handed over to the result register; a stalled
// result beat that blocks a further frame end adds its stall time. The first
// frame only fills the store and reports zero metrics with first_frame set.
// Frame lengths of zero act as one, and lengths above MAX_PIXELS act as
// MAX_PIXELS. The frame length register may be written only while no frame is
// in progress.
// ----------------------------------------------------------------------------
module frame_difference_metrics_core
   import fdm_pkg::*;
#(
   parameter int unsigned MAX_PIXELS = FDM_MAX_PIXELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [LUMA_W-1:0]         req_luma,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [FRAME_NUMBER_W-1:0] rsp_frame_number,
   output logic                      rsp_first_frame,
   output logic [SUM_SQUARES_W-1:0]  rsp_sum_squares,
   output logic [RMS_ROOT_W-1:0]     rsp_rms_root,
   output logic [SUM_ABSOLUTE_W-1:0] rsp_sum_absolute,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [FRAME_PIXELS_W-1:0] csr_frame_pixels
);

   localparam int unsigned AW = $clog2(MAX_PIXELS);
   localparam int unsigned LW = (AW + 1 > FRAME_PIXELS_W) ? AW + 1 : FRAME_PIXELS_W;
   localparam int unsigned LEN_RESET =
      (FRAME_PIXELS_RESET > MAX_PIXELS) ? MAX_PIXELS : FRAME_PIXELS_RESET;

   logic [LW-1:0]             len_ff, len_in;
   logic [LW-1:0]             csr_wide;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [LW-1:0]             pos_next;
   logic                      pix_last;
   logic                      accept;
   logic [LUMA_W-1:0]         old_luma;
   logic                      last_in_flight;
   logic                      sum_valid;
   frame_sum_type             sum;
   sqrt_status_type           sqrt_status;
   frame_sum_type             sqrt_sum;
   logic [RMS_ROOT_W-1:0]     sqrt_root;
   logic                      rsp_load;
   logic                      rsp_valid_ff, rsp_valid_in;
   frame_sum_type             rsp_sum_ff;
   logic [RMS_ROOT_W-1:0]     rsp_root_ff;

   // The frame length is clamped when written, so the compare stays narrow.
   assign csr_ready = 1'b1;
   assign csr_wide  = LW'(csr_frame_pixels);

   always_comb begin
      len_in = len_ff;
      if (csr_valid) begin
         if (csr_wide == '0) begin
            len_in = LW'(1);
         end else if (csr_wide > LW'(MAX_PIXELS)) begin
            len_in = LW'(MAX_PIXELS);
         end else begin
            len_in = csr_wide;
         end
      end
   end

   assign req_stall = last_in_flight | sqrt_status.busy;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      pos_next = LW'(pos_ff) + LW'(1);
      pix_last = pos_next >= len_ff;
      pos_in   = pos_ff;
      if (accept) begin
         pos_in = pix_last ? '0 : pos_next[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LW'(LEN_RESET);
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   fdm_pixel_ram #(
      .DEPTH (MAX_PIXELS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .access  (accept),
      .addr    (pos_ff),
      .wr_data (req_luma),
      .rd_data (old_luma)
   );

   fdm_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .pix_valid      (accept),
      .pix_last       (pix_last),
      .pix_luma       (req_luma),
      .old_luma       (old_luma),
      .last_in_flight (last_in_flight),
      .sum_valid      (sum_valid),
      .sum            (sum)
   );

   fdm_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sum_valid),
      .sum_in  (sum),
      .take    (rsp_load),
      .status  (sqrt_status),
      .sum_out (sqrt_sum),
      .root    (sqrt_root)
   );

   // Result register: a finished root moves in once the previous beat is gone.
   assign rsp_load     = sqrt_status.done & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sum_ff  <= sqrt_sum;
         rsp_root_ff <= sqrt_root;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_number = rsp_sum_ff.frame_number;
   assign rsp_first_frame  = rsp_sum_ff.first_frame;
   assign rsp_sum_squares  = rsp_sum_ff.sum_squares;
   assign rsp_rms_root     = rsp_root_ff;
   assign rsp_sum_absolute = rsp_sum_ff.sum_absolute;

endmodule
